/* hdl/frcs_pkg.sv */
// ----------------------------------------------------------------------------
// frcs_pkg
// Types and constants shared by the floppy read command sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package frcs_pkg;

  // action kinds
  localparam logic [1:0] KIND_PORT = 2'd0;
  localparam logic [1:0] KIND_FDC  = 2'd1;
  localparam logic [1:0] KIND_WAIT = 2'd2;
  localparam logic [1:0] KIND_COPY = 2'd3;

  // i/o ports
  localparam logic [9:0] PORT_DOR       = 10'h3f2;
  localparam logic [9:0] PORT_FDC_DATA  = 10'h3f5;
  localparam logic [9:0] PORT_DMA_MODE  = 10'h00b;
  localparam logic [9:0] PORT_DMA_ADDR  = 10'h004;
  localparam logic [9:0] PORT_DMA_PAGE  = 10'h081;
  localparam logic [9:0] PORT_DMA_CNT   = 10'h005;
  localparam logic [9:0] PORT_DMA_MASK  = 10'h00a;

  // data bytes
  localparam logic [7:0] DOR_MOTOR_ON   = 8'h1c;
  localparam logic [7:0] DOR_MOTOR_OFF  = 8'h00;
  localparam logic [7:0] CMD_RECAL      = 8'h07;
  localparam logic [7:0] CMD_SEEK       = 8'h0f;
  localparam logic [7:0] CMD_READ       = 8'he6;
  localparam logic [7:0] DMA_MODE_READ  = 8'h46;
  localparam logic [7:0] DMA_UNMASK_CH2 = 8'h02;
  localparam logic [7:0] DRIVE_ZERO     = 8'h00;
  localparam logic [7:0] START_SECTOR   = 8'h01;
  localparam logic [7:0] SIZE_CODE      = 8'h02;
  localparam logic [7:0] GAP_LEN        = 8'd27;
  localparam logic [7:0] DATA_LEN       = 8'hff;

  localparam logic [16:0] BYTES_MAX     = 17'h1ffff;

  typedef struct packed {
    logic        job_type;
    logic [15:0] lba;
    logic [7:0]  sector_count;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  port;
    logic [7:0]  data;
    logic [15:0] copy_offset;
    logic [16:0] copy_bytes;
    logic        rejected;
    logic        last;
  } out_t;

  // classified job handed from front to back
  typedef struct packed {
    logic        is_write;
    logic        head;
    logic [7:0]  track;
    logic [15:0] copy_offset;
    logic [16:0] copy_bytes;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_st_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_st_t;

  // one member per action of a read run, in order
  typedef enum logic [4:0] {
    A_MOTOR_ON,
    A_WAIT_MOTOR,
    A_RECAL_CMD,
    A_RECAL_DRV,
    A_WAIT_RECAL,
    A_SEEK_CMD,
    A_SEEK_HD,
    A_SEEK_TRK,
    A_WAIT_SEEK,
    A_DMA_MODE,
    A_DMA_ADDR_LO,
    A_DMA_ADDR_HI,
    A_DMA_PAGE,
    A_DMA_CNT_LO,
    A_DMA_CNT_HI,
    A_DMA_UNMASK,
    A_RD_CMD,
    A_RD_HD,
    A_RD_TRK,
    A_RD_HEAD,
    A_RD_SEC,
    A_RD_SIZE,
    A_RD_EOT,
    A_RD_GAP,
    A_RD_DTL,
    A_WAIT_READ,
    A_COPY,
    A_MOTOR_OFF
  } act_t;

endpackage

`default_nettype wire

/* hdl/floppy_read_command_sequencer.sv */
// a read request gives 28 results on consecutive cycles, the first after the front's divide
// and push states, the queue and the registered result port; a write request gives its one
// rejected result; the read rate is set by the back sequencer giving one action per cycle;
// the front takes no new request until it has pushed the last, which sets the write rate
// reset (rst_n low, synchronous) empties the queue and idles both sequencers
// results come as one-cycle strobes and the receiver cannot stall them
// ----------------------------------------------------------------------------
// floppy_read_command_sequencer
// Turns floppy jobs into the ordered run of port, controller, wait and copy
// actions for a read; write jobs are rejected.
// ----------------------------------------------------------------------------
`default_nettype none

module floppy_read_command_sequencer
  import frcs_pkg::*;
#(
  parameter int SECTOR_BYTES  = 512,
  parameter int TRACK_SECTORS = 18
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire in_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output out_t      out_data
);

  q_stat_t q_stat;
  logic    push;
  job_t    push_data;
  logic    pop;
  job_t    pop_data;

  frcs_front #(
    .SECTOR_BYTES  (SECTOR_BYTES),
    .TRACK_SECTORS (TRACK_SECTORS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  frcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  frcs_back #(
    .SECTOR_BYTES  (SECTOR_BYTES),
    .TRACK_SECTORS (TRACK_SECTORS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* hdl/frcs_front.sv */
// ----------------------------------------------------------------------------
// frcs_front
// Accepts jobs, splits the sector number into head, track and sector with a
// reciprocal multiply, and pushes the classified job into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module frcs_front
  import frcs_pkg::*;
#(
  parameter int SECTOR_BYTES  = 512,
  parameter int TRACK_SECTORS = 18
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire in_t     in_data,
  output logic         busy,
  input  wire q_stat_t q_stat,
  output logic         push,
  output job_t         push_data
);

  localparam logic [6:0]  CYL_SECTORS = 7'(2 * TRACK_SECTORS);
  localparam logic [6:0]  TRK_SECTORS = 7'(TRACK_SECTORS);
  // ceil(2^23 / sectors per cylinder), exact quotient for every 16-bit lba
  localparam logic [19:0] CYL_RECIP   =
    20'((2 ** 23 + 2 * TRACK_SECTORS - 1) / (2 * TRACK_SECTORS));

  front_st_t   state_r, state_nxt;
  logic [15:0] lba_r;
  logic [11:0] quo_r;
  logic [6:0]  rem_r;
  logic        is_write_r;
  logic [7:0]  count_r;

  logic [34:0] quo_prod;
  logic [15:0] cyl_base;
  logic [6:0]  cyl_rem;
  logic        head;
  logic [5:0]  sec;
  logic [21:0] off_full;
  logic [18:0] bytes_full;
  logic        accept;

  assign accept = start && (state_r == F_IDLE);

  // quotient at accept, remainder in the following cycle
  assign quo_prod = 35'(in_data.lba) * 35'(CYL_RECIP);
  assign cyl_base = 16'(quo_r) * 16'(CYL_SECTORS);
  // remainder is below 128, so the low bits of the difference are enough
  assign cyl_rem  = 7'(lba_r - cyl_base);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (start) begin
          state_nxt = in_data.job_type ? F_PUSH : F_DIV;
        end
      end
      F_DIV: begin
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_stat.full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r != F_IDLE);
    push = (state_r == F_PUSH) && !q_stat.full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lba_r      <= in_data.lba;
      quo_r      <= quo_prod[34:23];
      is_write_r <= in_data.job_type;
      count_r    <= in_data.sector_count;
    end else if (state_r == F_DIV) begin
      rem_r <= cyl_rem;
    end
  end

  // remainder of the cylinder split gives head and sector in track
  always_comb begin
    head       = (rem_r >= TRK_SECTORS);
    sec        = head ? 6'(rem_r - TRK_SECTORS) : rem_r[5:0];
    off_full   = 22'(sec) * 22'(SECTOR_BYTES);
    bytes_full = 19'(count_r) * 19'(SECTOR_BYTES);

    push_data             = '0;
    push_data.is_write    = is_write_r;
    push_data.head        = head;
    push_data.track       = quo_r[7:0];
    push_data.copy_offset = off_full[15:0];
    push_data.copy_bytes  = (bytes_full > 19'(BYTES_MAX)) ? BYTES_MAX : bytes_full[16:0];
  end

endmodule

`default_nettype wire

/* hdl/frcs_queue.sv */
// ----------------------------------------------------------------------------
// frcs_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module frcs_queue
  import frcs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_data,
  input  wire logic pop,
  output job_t      pop_data,
  output q_stat_t   q_stat
);

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign pop_data     = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);

endmodule

`default_nettype wire

/* hdl/frcs_back.sv */
// ----------------------------------------------------------------------------
// frcs_back
// Pulls jobs from the queue and steps through the action run, one action
// per cycle, into the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module frcs_back
  import frcs_pkg::*;
#(
  parameter int SECTOR_BYTES  = 512,
  parameter int TRACK_SECTORS = 18
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire q_stat_t q_stat,
  input  wire job_t    pop_data,
  output logic         pop,
  output logic         out_valid,
  output out_t         out_data
);

  localparam logic [15:0] DMA_CNT = 16'(SECTOR_BYTES * TRACK_SECTORS - 1);
  localparam logic [7:0]  EOT     = 8'(TRACK_SECTORS);

  back_st_t state_r, state_nxt;
  act_t     step_r;
  job_t     job_r;
  logic     at_end;
  logic     valid_nxt;
  out_t     out_nxt;
  logic     out_valid_r;
  out_t     out_data_r;
  logic [7:0] hd_byte;

  assign at_end = job_r.is_write || (step_r == A_MOTOR_OFF);
  assign pop    = !q_stat.empty && ((state_r == B_IDLE) || at_end);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        if (at_end && q_stat.empty) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    hd_byte   = {5'b0, job_r.head, 2'b0};
    valid_nxt = (state_r == B_RUN);
    out_nxt   = '0;
    if (job_r.is_write) begin
      out_nxt.rejected = 1'b1;
      out_nxt.last     = 1'b1;
    end else begin
      case (step_r)
        A_MOTOR_ON: begin
          out_nxt.kind = KIND_PORT; out_nxt.port = PORT_DOR; out_nxt.data = DOR_MOTOR_ON;
        end
        A_WAIT_MOTOR, A_WAIT_RECAL, A_WAIT_SEEK, A_WAIT_READ: begin
          out_nxt.kind = KIND_WAIT;
        end
        A_RECAL_CMD: begin
          out_nxt.kind = KIND_FDC; out_nxt.port = PORT_FDC_DATA; out_nxt.data = CMD_RECAL;
        end
        A_RECAL_DRV: begin
          out_nxt.kind = KIND_FDC; out_nxt.port = PORT_FDC_DATA; out_nxt.data = DRIVE_ZERO;
        end
        A_SEEK_CMD: begin
          out_nxt.kind = KIND_FDC; out_nxt.port = PORT_FDC_DATA; out_nxt.data = CMD_SEEK;
        end
        A_SEEK_HD, A_RD_HD: begin
          out_nxt.kind = KIND_FDC; out_nxt.port = PORT_FDC_DATA; out_nxt.data = hd_byte;
        end
        A_SEEK_TRK, A_RD_TRK: begin
          out_nxt.kind = KIND_FDC; out_nxt.port = PORT_FDC_DATA; out_nxt.data = job_r.track;
        end
        A_DMA_MODE: begin
          out_nxt.kind = KIND_PORT; out_nxt.port = PORT_DMA_MODE; out_nxt.data = DMA_MODE_READ;
        end
        A_DMA_ADDR_LO, A_DMA_ADDR_HI: begin
          out_nxt.kind = KIND_PORT; out_nxt.port = PORT_DMA_ADDR;
        end
        A_DMA_PAGE: begin
          out_nxt.kind = KIND_PORT; out_nxt.port = PORT_DMA_PAGE;
        end
        A_DMA_CNT_LO: begin
          out_nxt.kind = KIND_PORT; out_nxt.port = PORT_DMA_CNT; out_nxt.data = DMA_CNT[7:0];
        end
        A_DMA_CNT_HI: begin
          out_nxt.kind = KIND_PORT; out_nxt.port = PORT_DMA_CNT; out_nxt.data = DMA_CNT[15:8];
        end
        A_DMA_UNMASK: begin
          out_nxt.kind = KIND_PORT; out_nxt.port = PORT_DMA_MASK; out_nxt.data = DMA_UNMASK_CH2;
        end
        A_RD_CMD: begin
          out_nxt.kind = KIND_FDC; out_nxt.port = PORT_FDC_DATA; out_nxt.data = CMD_READ;
        end
        A_RD_HEAD: begin
          out_nxt.kind = KIND_FDC; out_nxt.port = PORT_FDC_DATA;
          out_nxt.data = {7'b0, job_r.head};
        end
        A_RD_SEC: begin
          out_nxt.kind = KIND_FDC; out_nxt.port = PORT_FDC_DATA; out_nxt.data = START_SECTOR;
        end
        A_RD_SIZE: begin
          out_nxt.kind = KIND_FDC; out_nxt.port = PORT_FDC_DATA; out_nxt.data = SIZE_CODE;
        end
        A_RD_EOT: begin
          out_nxt.kind = KIND_FDC; out_nxt.port = PORT_FDC_DATA; out_nxt.data = EOT;
        end
        A_RD_GAP: begin
          out_nxt.kind = KIND_FDC; out_nxt.port = PORT_FDC_DATA; out_nxt.data = GAP_LEN;
        end
        A_RD_DTL: begin
          out_nxt.kind = KIND_FDC; out_nxt.port = PORT_FDC_DATA; out_nxt.data = DATA_LEN;
        end
        A_COPY: begin
          out_nxt.kind        = KIND_COPY;
          out_nxt.copy_offset = job_r.copy_offset;
          out_nxt.copy_bytes  = job_r.copy_bytes;
        end
        A_MOTOR_OFF: begin
          out_nxt.kind = KIND_PORT; out_nxt.port = PORT_DOR; out_nxt.data = DOR_MOTOR_OFF;
          out_nxt.last = 1'b1;
        end
        default: out_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
    if (pop) begin
      job_r  <= pop_data;
      step_r <= A_MOTOR_ON;
    end else if (state_r == B_RUN) begin
      step_r <= act_t'(step_r + 5'd1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* bench/floppy_read_command_sequencer_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// floppy_read_command_sequencer_check
// Watches the request and action channels of the sequencer, builds the action
// run each accepted request should give and compares every action in order.
// ----------------------------------------------------------------------------

module floppy_read_command_sequencer_check
  import frcs_pkg::*;
#(
  parameter int SECTOR_BYTES  = 512,
  parameter int TRACK_SECTORS = 18
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire in_t  in_data,
  input  wire logic busy,
  input  wire logic out_valid,
  input  wire out_t out_data,
  output int        fail_count,
  output int        pending_actions
);

  out_t expected_actions[$];
  out_t oldest_action;

  initial begin
    fail_count      = 0;
    pending_actions = 0;
  end

  task automatic push_action(input logic [1:0] kind, input logic [9:0] port,
                             input logic [7:0] data);
    out_t a;
    a      = '0;
    a.kind = kind;
    a.port = port;
    a.data = data;
    expected_actions.push_back(a);
  endtask

  task automatic push_fdc_byte(input logic [7:0] data);
    push_action(KIND_FDC, PORT_FDC_DATA, data);
  endtask

  task automatic push_wait();
    push_action(KIND_WAIT, '0, '0);
  endtask

  task automatic add_expected_actions(input in_t req);
    out_t        a;
    int unsigned lba_n;
    int unsigned head_n;
    int unsigned nbytes;
    logic [7:0]  track;
    logic [7:0]  head_drive;
    logic [15:0] dma_count;
    logic [15:0] offset;
    begin
      a = '0;
      if (req.job_type) begin
        // write request: one rejected action and nothing else
        a.rejected = 1'b1;
        a.last     = 1'b1;
        expected_actions.push_back(a);
      end else begin
        lba_n      = 32'(req.lba);
        head_n     = (lba_n % (2 * TRACK_SECTORS)) / TRACK_SECTORS;
        track      = 8'((lba_n / (2 * TRACK_SECTORS)) & 32'hff);
        head_drive = 8'((head_n << 2) & 32'hff);
        dma_count  = 16'((SECTOR_BYTES * TRACK_SECTORS - 1) & 32'hffff);
        offset     = 16'(((lba_n % TRACK_SECTORS) * SECTOR_BYTES) & 32'hffff);
        nbytes     = 32'(req.sector_count) * SECTOR_BYTES;
        if (nbytes > 32'(BYTES_MAX)) nbytes = 32'(BYTES_MAX);

        push_action(KIND_PORT, PORT_DOR, DOR_MOTOR_ON);
        push_wait();
        push_fdc_byte(CMD_RECAL);
        push_fdc_byte(DRIVE_ZERO);
        push_wait();
        push_fdc_byte(CMD_SEEK);
        push_fdc_byte(head_drive);
        push_fdc_byte(track);
        push_wait();
        push_action(KIND_PORT, PORT_DMA_MODE, DMA_MODE_READ);
        push_action(KIND_PORT, PORT_DMA_ADDR, 8'h00);
        push_action(KIND_PORT, PORT_DMA_ADDR, 8'h00);
        push_action(KIND_PORT, PORT_DMA_PAGE, 8'h00);
        push_action(KIND_PORT, PORT_DMA_CNT, dma_count[7:0]);
        push_action(KIND_PORT, PORT_DMA_CNT, dma_count[15:8]);
        push_action(KIND_PORT, PORT_DMA_MASK, DMA_UNMASK_CH2);
        push_fdc_byte(CMD_READ);
        push_fdc_byte(head_drive);
        push_fdc_byte(track);
        push_fdc_byte(8'(head_n));
        push_fdc_byte(START_SECTOR);
        push_fdc_byte(SIZE_CODE);
        push_fdc_byte(8'(TRACK_SECTORS & 32'hff));
        push_fdc_byte(GAP_LEN);
        push_fdc_byte(DATA_LEN);
        push_wait();

        a.kind        = KIND_COPY;
        a.copy_offset = offset;
        a.copy_bytes  = 17'(nbytes);
        expected_actions.push_back(a);

        a      = '0;
        a.kind = KIND_PORT;
        a.port = PORT_DOR;
        a.data = DOR_MOTOR_OFF;
        a.last = 1'b1;
        expected_actions.push_back(a);
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [16:0] want,
                                      input logic [16:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (start === 1'b1 && busy === 1'b0) add_expected_actions(in_data);
      if (out_valid === 1'b1) begin
        if (expected_actions.size() == 0) begin
          $display("%0t: unexpected action, expected none, actual %p", $time, out_data);
          fail_count++;
        end else begin
          oldest_action = expected_actions.pop_front();
          check_field("kind", 17'(oldest_action.kind), 17'(out_data.kind));
          check_field("port", 17'(oldest_action.port), 17'(out_data.port));
          check_field("data", 17'(oldest_action.data), 17'(out_data.data));
          check_field("copy_offset", 17'(oldest_action.copy_offset),
                      17'(out_data.copy_offset));
          check_field("copy_bytes", oldest_action.copy_bytes, out_data.copy_bytes);
          check_field("rejected", 17'(oldest_action.rejected), 17'(out_data.rejected));
          check_field("last", 17'(oldest_action.last), 17'(out_data.last));
        end
      end
    end
    // registered, so the stimulus sees it late, which only makes draining conservative
    pending_actions <= expected_actions.size();
  end

endmodule

/* bench/floppy_read_command_sequencer_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// floppy_read_command_sequencer_test
// Drives directed and random floppy requests into the sequencer with varying
// request gaps; the checker predicts and compares every action of each run.
// ----------------------------------------------------------------------------

module floppy_read_command_sequencer_test;
  import frcs_pkg::*;

  localparam int SECTOR_BYTES  = 512;
  localparam int TRACK_SECTORS = 18;
  localparam int CYL_SECTORS   = 2 * TRACK_SECTORS;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_JOBS    = 64;
  localparam int TAIL_CYCLES   = 60;

  logic clk     = 1'b0;
  logic rst_n   = 1'b0;
  logic start   = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;
  int   fail_count;
  int   pending_actions;
  int   stall_cycles = 0;

  always #5 clk = ~clk;

  floppy_read_command_sequencer #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .TRACK_SECTORS(TRACK_SECTORS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  floppy_read_command_sequencer_check #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .TRACK_SECTORS(TRACK_SECTORS)
  ) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_data        (in_data),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending_actions(pending_actions)
  );

  // ends the run when neither a request nor an action moves for too long
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // holds start until the request is taken; start stays high on return
  task automatic send_request(input in_t req, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start   <= 1'b0;
      in_data <= in_t'($urandom);
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain_actions();
    start <= 1'b0;
    do @(posedge clk); while (pending_actions != 0);
  endtask

  task automatic run_random_phase(input int jobs, input int idle_pct, input int drain_at);
    in_t req;
    for (int i = 0; i < jobs; i++) begin
      req.job_type = ($urandom_range(0, 99) < 15);
      case ($urandom_range(0, 3))
        0, 1: req.lba = 16'($urandom);
        2:    req.lba = 16'($urandom_range(0, 4 * CYL_SECTORS));
        // around cylinder boundaries, head and track change here
        default: req.lba = 16'(CYL_SECTORS * $urandom_range(1, 1819)
                               - 1 + $urandom_range(0, 1));
      endcase
      case ($urandom_range(0, 7))
        0:       req.sector_count = 8'h00;
        1:       req.sector_count = 8'hff;
        default: req.sector_count = 8'($urandom);
      endcase
      send_request(req, idle_pct);
      if (i == drain_at) drain_actions();
    end
  endtask

  initial begin
    in_t directed[$];

    // write requests, field extremes, head and track boundaries, track wrap
    directed.push_back('{1'b1, 16'h0000, 8'h00});
    directed.push_back('{1'b1, 16'hffff, 8'hff});
    directed.push_back('{1'b0, 16'h0000, 8'h00});
    directed.push_back('{1'b0, 16'h0000, 8'h01});
    directed.push_back('{1'b0, 16'd17, 8'hff});
    directed.push_back('{1'b0, 16'd18, 8'h80});
    directed.push_back('{1'b0, 16'd35, 8'h7f});
    directed.push_back('{1'b0, 16'd36, 8'h02});
    directed.push_back('{1'b1, 16'd36, 8'h02});
    directed.push_back('{1'b0, 16'd9215, 8'h10});
    directed.push_back('{1'b0, 16'd9216, 8'h11});
    directed.push_back('{1'b0, 16'd9234, 8'h00});
    directed.push_back('{1'b0, 16'hffff, 8'hff});
    directed.push_back('{1'b0, 16'hffff, 8'h00});
    directed.push_back('{1'b0, 16'haaaa, 8'h55});
    directed.push_back('{1'b0, 16'h5555, 8'haa});
    directed.push_back('{1'b1, 16'h5555, 8'haa});
    directed.push_back('{1'b0, 16'h8000, 8'h40});
    directed.push_back('{1'b0, 16'h7fff, 8'h01});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_request(directed[i], 0);
    drain_actions();

    run_random_phase(PHASE_JOBS, 8, PHASE_JOBS / 2);
    drain_actions();
    run_random_phase(PHASE_JOBS, 87, -1);
    drain_actions();
    run_random_phase(PHASE_JOBS, 0, -1);
    drain_actions();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
